// File: hw/rtl/msie_pkg.sv
// Shared types, constants and opcodes for the MIPS subset executor.
package msie_pkg;

   localparam int MemWords = 4096;
   localparam int MemAddrBits = $clog2(MemWords);

   localparam logic [31:0] PC_START = 32'h0000_0040;
   localparam logic [31:0] PC_LIMIT = 32'h0000_1000;
   localparam logic [31:0] PC_STEP = 32'd2;
   localparam logic [31:0] JUMP_MASK = 32'hF800_0000;
   localparam logic [31:0] SYS_EXIT = 32'd10;
   localparam logic [4:0] REG_V0 = 5'd2;

   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_EXIT = 3'd1;
   localparam logic [2:0] ST_BADSYS = 3'd2;
   localparam logic [2:0] ST_ILLEGAL = 3'd3;
   localparam logic [2:0] ST_DIVZERO = 3'd4;

   localparam logic [5:0] OP_SPECIAL = 6'd0;
   localparam logic [5:0] OP_J = 6'd2;
   localparam logic [5:0] OP_BEQ = 6'd4;
   localparam logic [5:0] OP_BNE = 6'd5;
   localparam logic [5:0] OP_ADDI = 6'd8;
   localparam logic [5:0] OP_LUI = 6'd15;
   localparam logic [5:0] OP_SW = 6'd37;
   localparam logic [5:0] OP_LW = 6'd43;

   localparam logic [5:0] FN_SYSCALL = 6'd12;
   localparam logic [5:0] FN_DIV = 6'd26;
   localparam logic [5:0] FN_DIVU = 6'd27;
   localparam logic [5:0] FN_ADD = 6'd32;
   localparam logic [5:0] FN_ADDU = 6'd33;
   localparam logic [5:0] FN_SUB = 6'd34;
   localparam logic [5:0] FN_SUBU = 6'd35;
   localparam logic [5:0] FN_AND = 6'd36;
   localparam logic [5:0] FN_SLT = 6'd42;

   typedef struct packed {
      logic        kind;
      logic [31:0] instruction;
      logic [11:0] preload_index;
      logic [31:0] preload_value;
   } req_type;

   typedef struct packed {
      logic [31:0] next_pc;
      logic [2:0]  status;
      logic        reg_written;
      logic [4:0]  reg_index;
      logic [31:0] reg_value;
      logic        store_done;
      logic [31:0] store_address;
      logic [31:0] store_value;
   } rsp_type;

   typedef struct packed {
      logic        start;
      logic        is_signed;
      logic [31:0] dividend;
      logic [31:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] quotient;
   } div_rsp_type;

endpackage

// File: hw/rtl/mips_subset_instruction_executor.sv
// Top level: multicycle MIPS subset core with register file and data memory.
//   channel | direction | handshake
//   req_    | in        | req_valid / req_ready, req_data
//   rsp_    | out       | rsp_valid / rsp_ready, rsp_data
// Each item: accept (register file read registered at accept), execute in decode,
// then lw reads data memory in the load state; result lands in the output register.
// No new item is accepted until the result is in the output register; div/divu
// wait on the 32-step divider; preloads and items while halted skip execution.
// Reset: synchronous; registers zeroed by a clearing pass through all 32 entries of
// the register file, during which no item is accepted. Data memory is not cleared.
// A stalled result holds in the output register; the next item is taken then.
module mips_subset_instruction_executor (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  msie_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output msie_pkg::rsp_type rsp_data
);
   import msie_pkg::*;

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_DECODE, S_DIV, S_LOAD, S_OUT
   } state_type;

   state_type   state_ff;
   logic [4:0]  clr_ff;
   logic [31:0] pc_ff;
   logic        halted_ff;
   logic [2:0]  hcode_ff;
   logic [31:0] ir_ff;
   logic [31:0] v0_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff, res;
   rsp_type     held_rsp, load_rsp, div_done_rsp;
   logic [31:0] dmem [MemWords];
   logic [31:0] dmem_q;

   logic [31:0] a, b, imm, sum, pc_next;
   logic [5:0]  op, fn;
   logic [4:0]  rs, rt, rd;
   logic        rf_we;
   logic [4:0]  rf_wa;
   logic [31:0] rf_wd;
   logic        take;
   logic        dm_we;
   logic [MemAddrBits-1:0] dm_wa, dm_ra;
   logic [31:0] dm_wd;
   div_req_type div_req;
   div_rsp_type div_rsp;
   logic        need_div;

   assign op = ir_ff[31:26];
   assign rs = ir_ff[25:21];
   assign rt = ir_ff[20:16];
   assign rd = ir_ff[15:11];
   assign fn = ir_ff[5:0];
   assign imm = {{16{ir_ff[15]}}, ir_ff[15:0]};

   msie_regfile u_rf (
      .clock(clock),
      .rd_addr_a(take ? req_data.instruction[25:21] : rs),
      .rd_addr_b(take ? req_data.instruction[20:16] : rt),
      .rd_data_a(a),
      .rd_data_b(b),
      .wr_en(rf_we),
      .wr_addr(rf_wa),
      .wr_data(rf_wd)
   );

   msie_divider u_div (
      .clock(clock),
      .reset(reset),
      .div_req(div_req),
      .div_rsp(div_rsp)
   );

   assign req_ready = (state_ff == S_IDLE) || (state_ff == S_OUT && rsp_ready);
   assign take = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   always_comb begin
      sum = a + imm;
      pc_next = pc_ff + PC_STEP;
      if (pc_next >= PC_LIMIT) begin
         pc_next = PC_START;
      end
      res = '0;
      res.next_pc = pc_next;
      res.status = ST_OK;
      need_div = 1'b0;
      unique case (op)
         OP_SPECIAL: begin
            unique case (fn)
               FN_SYSCALL: res.status = (v0_ff == SYS_EXIT) ? ST_EXIT : ST_BADSYS;
               FN_DIV, FN_DIVU: begin
                  if (b == '0) begin
                     res.status = ST_DIVZERO;
                  end else begin
                     need_div = 1'b1;
                  end
               end
               FN_ADD, FN_ADDU: begin
                  res.reg_written = 1'b1; res.reg_index = rd; res.reg_value = a + b;
               end
               FN_SUB, FN_SUBU: begin
                  res.reg_written = 1'b1; res.reg_index = rd; res.reg_value = a - b;
               end
               FN_AND: begin
                  res.reg_written = 1'b1; res.reg_index = rd; res.reg_value = a & b;
               end
               FN_SLT: begin
                  res.reg_written = 1'b1; res.reg_index = rd;
                  res.reg_value = {31'd0, $signed(a) < $signed(b)};
               end
               default: res.status = ST_ILLEGAL;
            endcase
         end
         OP_LW: begin
            res.reg_written = 1'b1; res.reg_index = rt;
         end
         OP_SW: begin
            res.store_done = 1'b1; res.store_address = sum; res.store_value = b;
         end
         OP_BEQ: if (a == b) res.next_pc = pc_next + {imm[30:0], 1'b0};
         OP_BNE: if (a != b) res.next_pc = pc_next + {imm[30:0], 1'b0};
         OP_J: res.next_pc = (pc_next & JUMP_MASK) | {5'd0, ir_ff[25:0], 1'b0};
         OP_ADDI: begin
            res.reg_written = 1'b1; res.reg_index = rt; res.reg_value = sum;
         end
         OP_LUI: begin
            res.reg_written = 1'b1; res.reg_index = rt;
            res.reg_value = {ir_ff[15:0], 16'd0};
         end
         default: res.status = ST_ILLEGAL;
      endcase
      // drop writes to register zero
      if (res.reg_index == '0) begin
         res.reg_written = 1'b0;
         res.reg_value = '0;
      end
      held_rsp = '0;
      held_rsp.next_pc = pc_ff;
      held_rsp.status = hcode_ff;
      load_rsp = rsp_ff;
      if (rsp_ff.reg_written) begin
         load_rsp.reg_value = dmem_q;
      end
      div_done_rsp = rsp_ff;
      if (rd != '0) begin
         div_done_rsp.reg_written = 1'b1;
         div_done_rsp.reg_index = rd;
         div_done_rsp.reg_value = div_rsp.quotient;
      end
      div_req.start = (state_ff == S_DECODE) && need_div;
      div_req.is_signed = (fn == FN_DIV);
      div_req.dividend = a;
      div_req.divisor = b;
      dm_ra = sum[MemAddrBits+1:2];
      dm_we = 1'b0;
      dm_wa = sum[MemAddrBits+1:2];
      dm_wd = b;
      if (take && req_data.kind) begin
         dm_we = 1'b1;
         dm_wa = req_data.preload_index[MemAddrBits-1:0];
         dm_wd = req_data.preload_value;
      end else if (state_ff == S_DECODE && op == OP_SW) begin
         dm_we = 1'b1;
      end
      rf_we = 1'b0;
      rf_wa = rsp_ff.reg_index;
      rf_wd = rsp_ff.reg_value;
      if (state_ff == S_CLEAR) begin
         rf_we = 1'b1; rf_wa = clr_ff; rf_wd = '0;
      end else if (state_ff == S_DECODE && !need_div && op != OP_LW) begin
         rf_we = res.reg_written && res.reg_index != '0;
         rf_wa = res.reg_index; rf_wd = res.reg_value;
      end else if (state_ff == S_LOAD) begin
         rf_we = rsp_ff.reg_index != '0;
         rf_wd = dmem_q;
      end else if (state_ff == S_DIV && div_rsp.done) begin
         rf_we = rd != '0;
         rf_wa = rd; rf_wd = div_rsp.quotient;
      end
   end

   always_ff @(posedge clock) begin
      if (dm_we) begin
         dmem[dm_wa] <= dm_wd;
      end
      dmem_q <= dmem[dm_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         pc_ff <= PC_START;
         halted_ff <= 1'b0;
         hcode_ff <= ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 5'd1;
               if (clr_ff == 5'd31) state_ff <= S_IDLE;
            end
            S_IDLE, S_OUT: begin
               if (take) begin
                  if (req_data.kind || halted_ff) begin
                     rsp_ff <= held_rsp;
                     rsp_valid_ff <= 1'b1;
                     state_ff <= S_OUT;
                  end else begin
                     ir_ff <= req_data.instruction;
                     rsp_valid_ff <= 1'b0;
                     state_ff <= S_DECODE;
                  end
               end else if (state_ff == S_OUT && rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff <= S_IDLE;
               end
            end
            S_DECODE: begin
               pc_ff <= res.next_pc;
               if (res.status != ST_OK) begin
                  halted_ff <= 1'b1;
                  hcode_ff <= res.status;
               end
               rsp_ff <= res;
               if (need_div) begin
                  state_ff <= S_DIV;
               end else if (op == OP_LW) begin
                  state_ff <= S_LOAD;
               end else begin
                  rsp_valid_ff <= 1'b1;
                  state_ff <= S_OUT;
               end
            end
            S_LOAD: begin
               rsp_ff <= load_rsp;
               rsp_valid_ff <= 1'b1;
               state_ff <= S_OUT;
            end
            S_DIV: begin
               if (div_rsp.done) begin
                  rsp_ff <= div_done_rsp;
                  rsp_valid_ff <= 1'b1;
                  state_ff <= S_OUT;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
         // v0 tracks register 2 for the syscall test
         if (rf_we && rf_wa == REG_V0) begin
            v0_ff <= rf_wd;
         end
      end
      if (reset) begin
         v0_ff <= '0;
      end
   end

   a_out_has_result: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_OUT |-> rsp_valid_ff || $past(rsp_ready))
      else $error("output state without result");
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DECODE || state_ff == S_DIV || state_ff == S_LOAD) |-> !req_ready)
      else $error("item taken while executing");
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      $past(halted_ff) && !$past(reset) |-> halted_ff)
      else $error("halt cleared without reset");
   a_no_r0_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.reg_written |-> rsp_ff.reg_index != '0)
      else $error("register zero reported written");
endmodule

// File: hw/rtl/msie_regfile.sv
// Register file: 32 x 32 synchronous memory, two read ports, one write port.
module msie_regfile (
   input  logic        clock,
   input  logic [4:0]  rd_addr_a,
   input  logic [4:0]  rd_addr_b,
   output logic [31:0] rd_data_a,
   output logic [31:0] rd_data_b,
   input  logic        wr_en,
   input  logic [4:0]  wr_addr,
   input  logic [31:0] wr_data
);
   logic [31:0] mem [32];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end
endmodule

// File: hw/rtl/msie_divider.sv
// Iterative radix-2 divider, signed or unsigned, one quotient bit per cycle.
module msie_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  msie_pkg::div_req_type div_req,
   output msie_pkg::div_rsp_type div_rsp
);
   import msie_pkg::*;

   logic [31:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [31:0] dvs_ff, dvs_in;
   logic        neg_ff, neg_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [32:0] trial;
   logic [31:0] mag_a, mag_b, qfinal;

   always_comb begin
      mag_a = (div_req.is_signed && div_req.dividend[31]) ? -div_req.dividend
                                                          : div_req.dividend;
      mag_b = (div_req.is_signed && div_req.divisor[31]) ? -div_req.divisor
                                                         : div_req.divisor;
      trial = {rem_ff, quo_ff[31]} - {1'b0, dvs_ff};
      rem_in = rem_ff;
      quo_in = quo_ff;
      dvs_in = dvs_ff;
      neg_in = neg_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         rem_in = '0;
         quo_in = mag_a;
         dvs_in = mag_b;
         neg_in = div_req.is_signed && (div_req.dividend[31] ^ div_req.divisor[31]);
         cnt_in = 6'd32;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[32]) begin
            rem_in = trial[31:0];
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = {rem_ff[30:0], quo_ff[31]};
            quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
      qfinal = neg_ff ? -quo_ff : quo_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quotient = qfinal;

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("divider done without busy");
   a_count_live: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff != 6'd0) else $error("divider busy with zero count");
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !div_req.start) else $error("divider restarted while busy");
endmodule

// File: tb/mips_subset_instruction_executor_check.sv
// Checker for the MIPS subset executor: predicts each result and compares it.
`timescale 1ns / 1ps
module mips_subset_instruction_executor_check
   import msie_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_data,
   output int      failures,
   output int      outstanding
);

   logic [31:0] gpr [32];
   logic [31:0] dmem [MemWords];
   logic [31:0] pc_model;
   logic        halted;
   logic [2:0]  halt_status;
   rsp_type     pending_outcomes [$];

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %h want %h", what, got, want);
      failures++;
   endtask

   function automatic rsp_type execute_item(input req_type it);
      rsp_type     r;
      logic [31:0] ir, a, b, imm, q, nxt, ma, mb, addr;
      logic [5:0]  op, fn;
      logic [4:0]  rs, rt, rd;
      r = '0;
      if (it.kind) begin
         dmem[it.preload_index] = it.preload_value;
         r.next_pc = pc_model;
         r.status = halt_status;
         return r;
      end
      if (halted) begin
         r.next_pc = pc_model;
         r.status = halt_status;
         return r;
      end
      ir = it.instruction;
      nxt = pc_model + PC_STEP;
      if (nxt >= PC_LIMIT) nxt = PC_START;
      op = ir[31:26];
      rs = ir[25:21];
      rt = ir[20:16];
      rd = ir[15:11];
      fn = ir[5:0];
      imm = {{16{ir[15]}}, ir[15:0]};
      a = gpr[rs];
      b = gpr[rt];
      r.status = ST_OK;
      case (op)
         OP_SPECIAL: begin
            r.reg_index = rd;
            case (fn)
               FN_SYSCALL: r.status = (gpr[REG_V0] == SYS_EXIT) ? ST_EXIT : ST_BADSYS;
               FN_DIV, FN_DIVU: begin
                  if (b == 32'd0) begin
                     r.status = ST_DIVZERO;
                  end else begin
                     if (fn == FN_DIVU) begin
                        q = a / b;
                     end else begin
                        ma = a[31] ? -a : a;
                        mb = b[31] ? -b : b;
                        q = ma / mb;
                        if (a[31] ^ b[31]) q = -q;
                     end
                     r.reg_written = 1'b1;
                     r.reg_value = q;
                  end
               end
               FN_ADD, FN_ADDU: begin
                  r.reg_written = 1'b1;
                  r.reg_value = a + b;
               end
               FN_SUB, FN_SUBU: begin
                  r.reg_written = 1'b1;
                  r.reg_value = a - b;
               end
               FN_AND: begin
                  r.reg_written = 1'b1;
                  r.reg_value = a & b;
               end
               FN_SLT: begin
                  r.reg_written = 1'b1;
                  r.reg_value = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
               end
               default: r.status = ST_ILLEGAL;
            endcase
         end
         OP_LW: begin
            addr = a + imm;
            r.reg_written = 1'b1;
            r.reg_index = rt;
            r.reg_value = dmem[addr[MemAddrBits+1:2]];
         end
         OP_SW: begin
            addr = a + imm;
            r.store_done = 1'b1;
            r.store_address = addr;
            r.store_value = b;
            dmem[addr[MemAddrBits+1:2]] = b;
         end
         OP_BEQ: if (a == b) nxt = nxt + (imm << 1);
         OP_BNE: if (a != b) nxt = nxt + (imm << 1);
         OP_J: nxt = (nxt & JUMP_MASK) | {5'd0, ir[25:0], 1'b0};
         OP_ADDI: begin
            r.reg_written = 1'b1;
            r.reg_index = rt;
            r.reg_value = a + imm;
         end
         OP_LUI: begin
            r.reg_written = 1'b1;
            r.reg_index = rt;
            r.reg_value = {ir[15:0], 16'h0000};
         end
         default: r.status = ST_ILLEGAL;
      endcase
      // drop writes to register zero
      if (r.reg_written && r.reg_index == 5'd0) r.reg_written = 1'b0;
      if (r.reg_written) begin
         gpr[r.reg_index] = r.reg_value;
      end else begin
         r.reg_index = 5'd0;
         r.reg_value = 32'd0;
      end
      pc_model = nxt;
      if (r.status != ST_OK) begin
         halted = 1'b1;
         halt_status = r.status;
      end
      r.next_pc = nxt;
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < 32; i++) gpr[i] = 32'd0;
         pc_model = PC_START;
         halted = 1'b0;
         halt_status = ST_OK;
         pending_outcomes.delete();
         failures = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_outcomes.size() == 0) begin
               report_mismatch("unexpected item, next_pc", rsp_data.next_pc, 32'd0);
            end else begin
               want = pending_outcomes.pop_front();
               if (rsp_data.next_pc !== want.next_pc)
                  report_mismatch("next_pc", rsp_data.next_pc, want.next_pc);
               if (rsp_data.status !== want.status)
                  report_mismatch("status", 32'(rsp_data.status), 32'(want.status));
               if (rsp_data.reg_written !== want.reg_written)
                  report_mismatch("reg_written", 32'(rsp_data.reg_written),
                                  32'(want.reg_written));
               if (rsp_data.reg_index !== want.reg_index)
                  report_mismatch("reg_index", 32'(rsp_data.reg_index),
                                  32'(want.reg_index));
               if (rsp_data.reg_value !== want.reg_value)
                  report_mismatch("reg_value", rsp_data.reg_value, want.reg_value);
               if (rsp_data.store_done !== want.store_done)
                  report_mismatch("store_done", 32'(rsp_data.store_done),
                                  32'(want.store_done));
               if (rsp_data.store_address !== want.store_address)
                  report_mismatch("store_address", rsp_data.store_address,
                                  want.store_address);
               if (rsp_data.store_value !== want.store_value)
                  report_mismatch("store_value", rsp_data.store_value, want.store_value);
            end
         end
         if (req_valid && req_ready) pending_outcomes.push_back(execute_item(req_data));
      end
      outstanding = pending_outcomes.size();
   end

endmodule

// File: tb/mips_subset_instruction_executor_test.sv
// Top of the MIPS subset executor testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module mips_subset_instruction_executor_test;
   import msie_pkg::*;

   localparam int ItemTarget = 1650;
   localparam int CycleLimit = 800000;
   localparam int HoldCycles = 300;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;
   int      failures;
   int      outstanding;

   logic ready_seen;
   bit   no_idle;
   int   hold_trigger;
   int   holds_served = 0;
   int   hold_left = 0;
   int   cycles = 0;
   int   sent;
   bit   loaded [MemWords];
   int   loaded_list [$];

   mips_subset_instruction_executor dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   mips_subset_instruction_executor_check chk (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .failures    (failures),
      .outstanding (outstanding)
   );

   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ready only changes at rising edges, so the falling-edge value holds at the next one
   always @(negedge clock) ready_seen = req_ready;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("simulation failed");
         $finish;
      end
   end

   // receiver: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (hold_trigger != holds_served) begin
         holds_served <= hold_trigger;
         hold_left <= HoldCycles;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= no_idle || ($urandom_range(99) >= 11);
      end
   end

   function automatic logic [31:0] r_word(input logic [5:0] fn, input logic [4:0] rs,
                                          input logic [4:0] rt, input logic [4:0] rd);
      return {OP_SPECIAL, rs, rt, rd, 5'($urandom_range(31)), fn};
   endfunction

   function automatic logic [31:0] i_word(input logic [5:0] op, input logic [4:0] rs,
                                          input logic [4:0] rt, input logic [15:0] imm);
      return {op, rs, rt, imm};
   endfunction

   task automatic send_item(input req_type it);
      while (!no_idle && $urandom_range(99) < 11) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_data <= it;
      req_valid <= 1'b1;
      if (it.kind && !loaded[it.preload_index]) begin
         loaded[it.preload_index] = 1'b1;
         loaded_list.push_back(int'(it.preload_index));
      end
      do @(posedge clock); while (!ready_seen);
      sent++;
   endtask

   task automatic run_word(input logic [31:0] ir);
      req_type it;
      it.kind = 1'b0;
      it.instruction = ir;
      it.preload_index = 12'($urandom);
      it.preload_value = $urandom;
      send_item(it);
   endtask

   task automatic preload(input logic [11:0] idx, input logic [31:0] val);
      req_type it;
      it.kind = 1'b1;
      it.instruction = $urandom;
      it.preload_index = idx;
      it.preload_value = val;
      send_item(it);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic send_random();
      int          pick;
      logic [4:0]  rs, rt, rd, rx;
      logic [11:0] idx;
      logic [5:0]  fn;
      pick = $urandom_range(99);
      rs = 5'($urandom);
      rt = 5'($urandom);
      rd = 5'($urandom);
      if (pick < 12) begin
         preload(12'($urandom), $urandom);
      end else if (pick < 22) begin
         // nonzero divisor first, then the divide
         rx = 5'($urandom_range(1, 31));
         if ($urandom_range(1))
            run_word(i_word(OP_LUI, rs, rx, 16'($urandom_range(1, 65535))));
         else
            run_word(i_word(OP_ADDI, 5'd0, rx, 16'($urandom_range(1, 65535))));
         run_word(r_word($urandom_range(1) ? FN_DIV : FN_DIVU, rs, rx, rd));
      end else if (pick < 32) begin
         // base register zero keeps the address on a loaded word
         idx = 12'(loaded_list[$urandom_range(loaded_list.size() - 1)]);
         run_word(i_word(OP_LW, 5'd0, rt,
                         {2'($urandom), idx, 2'($urandom)}));
      end else if (pick < 40) begin
         run_word(i_word(OP_SW, rs, rt, 16'($urandom)));
      end else if (pick < 50) begin
         if ($urandom_range(1)) rt = rs;
         run_word(i_word($urandom_range(1) ? OP_BEQ : OP_BNE, rs, rt, 16'($urandom)));
      end else if (pick < 55) begin
         run_word({OP_J, 26'($urandom)});
      end else if (pick < 65) begin
         run_word(i_word(OP_ADDI, rs, rt, 16'($urandom)));
      end else if (pick < 72) begin
         run_word(i_word(OP_LUI, rs, rt, 16'($urandom)));
      end else begin
         case ($urandom_range(5))
            0: fn = FN_ADD;
            1: fn = FN_ADDU;
            2: fn = FN_SUB;
            3: fn = FN_SUBU;
            4: fn = FN_AND;
            default: fn = FN_SLT;
         endcase
         run_word(r_word(fn, rs, rt, rd));
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      no_idle = 1'b0;
      hold_trigger = 0;
      sent = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      preload(12'd0, 32'd0);
      preload(12'hFFF, 32'hFFFF_FFFF);
      preload(12'h555, $urandom);
      run_word(i_word(OP_LUI, 5'd0, 5'd1, 16'h8000));
      run_word(i_word(OP_ADDI, 5'd0, 5'd2, 16'hFFFF));
      run_word(r_word(FN_DIV, 5'd1, 5'd2, 5'd3));
      run_word(r_word(FN_DIVU, 5'd1, 5'd2, 5'd4));
      run_word(r_word(FN_ADD, 5'd1, 5'd1, 5'd5));
      run_word(r_word(FN_ADDU, 5'd2, 5'd2, 5'd6));
      run_word(r_word(FN_SUB, 5'd0, 5'd1, 5'd7));
      run_word(r_word(FN_SUBU, 5'd1, 5'd2, 5'd8));
      run_word(r_word(FN_AND, 5'd1, 5'd2, 5'd9));
      run_word(r_word(FN_SLT, 5'd1, 5'd2, 5'd10));
      run_word(r_word(FN_SLT, 5'd2, 5'd1, 5'd11));
      run_word(i_word(OP_ADDI, 5'd2, 5'd0, 16'd5));
      run_word(r_word(FN_ADD, 5'd1, 5'd1, 5'd0));
      run_word(i_word(OP_LW, 5'd0, 5'd12, 16'h0000));
      run_word(i_word(OP_LW, 5'd0, 5'd13, 16'h3FFC));
      run_word(i_word(OP_LW, 5'd0, 5'd14, 16'hFFFC));
      run_word(i_word(OP_SW, 5'd2, 5'd1, 16'h8000));
      run_word(i_word(OP_BEQ, 5'd0, 5'd0, 16'hFFFF));
      run_word(i_word(OP_BNE, 5'd1, 5'd2, 16'h7FFF));
      run_word({OP_J, 26'h00007FF});
      run_word(i_word(OP_ADDI, 5'd0, 5'd15, 16'd1));
      run_word({OP_J, 26'h3FFFFFF});
      run_word(r_word(FN_ADDU, 5'd1, 5'd2, 5'd16));

      while (sent < ItemTarget) begin
         if (sent >= 500 && sent < 503) drain_results();
         if (sent >= 800 && hold_trigger == 0) hold_trigger = 1;
         no_idle = (sent >= 1000 && sent < 1250);
         send_random();
      end
      no_idle = 1'b0;

      // one halt at the end, then items that must see the held state
      case ($urandom_range(3))
         0: begin
            run_word(i_word(OP_ADDI, 5'd0, REG_V0, 16'(SYS_EXIT)));
            run_word(r_word(FN_SYSCALL, 5'($urandom), 5'($urandom), 5'($urandom)));
         end
         1: begin
            run_word(i_word(OP_ADDI, 5'd0, REG_V0, 16'($urandom_range(11, 65535))));
            run_word(r_word(FN_SYSCALL, 5'($urandom), 5'($urandom), 5'($urandom)));
         end
         2: run_word({6'd63, 26'($urandom)});
         default: run_word(r_word(FN_DIV, 5'($urandom), 5'd0, 5'($urandom)));
      endcase
      repeat (5) run_word($urandom);
      preload(12'($urandom), $urandom);
      run_word($urandom);

      drain_results();
      repeat (60) @(posedge clock);
      if (failures == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
